// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/txrc_pkg.sv
// ----------------------------------------------------------------------------
// txrc_pkg
// Shared types, command codes and defaults of the transmit ring coalescer.
// ----------------------------------------------------------------------------
package txrc_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 64;
    localparam int BUFFER_COUNT_DEFAULT = 4;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_DONE  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       last_of_write;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic [1:0] buffer_index;
        logic [6:0] tx_length;
        logic       last_byte;
        logic       overrun_flag;
    } out_item_t;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_ACCEPT,
        WS_DROP
    } wr_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SKIP,
        ST_CHECK,
        ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic len_at_send;
        logic lat_item;
        logic src_latched;
        logic wr_drop;
        logic wr_store;
        logic wr_advance;
        logic wr_exhaust;
        logic set_done;
        logic retire;
        logic start;
        logic send_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic wr_accept;
        logic fill_full;
        logic adv_hits_send;
        logic can_start;
        logic issue_last;
        logic done;
    } dp_status_t;

endpackage

// File: rtl/txrc_stream_if.sv
// ----------------------------------------------------------------------------
// txrc_stream_if
// Valid/ready item channel with a typed payload.
// ----------------------------------------------------------------------------
interface txrc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/txrc_ram.sv
// ----------------------------------------------------------------------------
// txrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module txrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/txrc_dp.sv
// ----------------------------------------------------------------------------
// txrc_dp
// Datapath: ring indices, buffer lengths, write state, byte store and the
// read/output stages that stream a buffer out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module txrc_dp #(
    parameter int BUFFER_BYTES = txrc_pkg::BUFFER_BYTES_DEFAULT,
    parameter int BUFFER_COUNT = txrc_pkg::BUFFER_COUNT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  txrc_pkg::ctrl_cmd_t  cmd,
    output txrc_pkg::dp_status_t sts,
    input  logic [7:0]           data_byte,
    input  logic                 last_of_write,
    input  logic                 tx_ready,
    output logic                 tx_valid,
    output txrc_pkg::out_item_t  tx_item
);

    localparam int IDX_W  = $clog2(BUFFER_COUNT);
    localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
    localparam int DEPTH  = BUFFER_COUNT * BUFFER_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [LEN_W-1:0]  LEN_FULL = LEN_W'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0]  LEN_LAST = LEN_W'(BUFFER_BYTES - 1);
    localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(BUFFER_COUNT - 1);
    localparam logic [ADDR_W-1:0] STRIDE   = ADDR_W'(BUFFER_BYTES);

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_MAX) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    logic [LEN_W-1:0]     len_reg [BUFFER_COUNT];
    logic [LEN_W-1:0]     len_next [BUFFER_COUNT];
    logic [IDX_W-1:0]     fill_reg, fill_next;
    logic [IDX_W-1:0]     send_reg, send_next;
    logic                 busy_reg, busy_next;
    logic                 ovr_reg, ovr_next;
    logic                 done_reg, done_next;
    txrc_pkg::wr_state_t  ws_reg, ws_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [LEN_W-1:0]     run_len_reg, run_len_next;
    logic [LEN_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    txrc_pkg::out_item_t  pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    txrc_pkg::out_item_t  out_reg, out_next;

    logic [7:0]           cur_byte;
    logic                 cur_last;
    logic [LEN_W-1:0]     len_rd;
    logic [IDX_W-1:0]     fill_nx;
    logic                 hits;
    logic                 store_fills;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 pend_move;
    logic                 issue;
    logic                 issue_last;
    logic                 wr_accept;
    logic [7:0]           ram_rd;

    assign cur_byte    = cmd.src_latched ? byte_reg : data_byte;
    assign cur_last    = cmd.src_latched ? last_reg : last_of_write;
    assign len_rd      = len_reg[cmd.len_at_send ? send_reg : fill_reg];
    assign fill_nx     = next_idx(fill_reg);
    assign hits        = (fill_nx == send_reg);
    assign store_fills = (len_rd == LEN_LAST);
    assign wr_addr     = ADDR_W'(fill_reg) * STRIDE + ADDR_W'(len_rd);
    assign rd_addr     = ADDR_W'(send_reg) * STRIDE + ADDR_W'(rd_cnt_reg);
    assign pend_move   = pend_valid_reg && (!out_valid_reg || tx_ready);
    assign issue       = cmd.send_en && (!pend_valid_reg || pend_move);
    assign issue_last  = issue && (rd_cnt_reg == LEN_W'(run_len_reg - 1'b1));
    assign wr_accept   = (ws_reg == txrc_pkg::WS_IDLE)
                       ? (!ovr_reg && (!busy_reg || fill_reg != send_reg))
                       : (ws_reg == txrc_pkg::WS_ACCEPT);

    always_comb
    begin
        sts.wr_accept     = wr_accept;
        sts.fill_full     = (len_rd == LEN_FULL);
        sts.adv_hits_send = hits;
        sts.can_start     = !busy_reg && (len_rd != '0);
        sts.issue_last    = issue_last;
        sts.done          = done_reg;
    end

    txrc_ram #(
        .WIDTH  (8),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_store),
        .wr_addr (wr_addr),
        .wr_data (cur_byte),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        len_next        = len_reg;
        fill_next       = fill_reg;
        send_next       = send_reg;
        busy_next       = busy_reg;
        ovr_next        = ovr_reg;
        done_next       = done_reg;
        ws_next         = ws_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        run_len_next    = run_len_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.lat_item)
        begin
            byte_next = data_byte;
            last_next = last_of_write;
        end
        if (cmd.set_done)
        begin
            done_next = 1'b1;
        end
        if (cmd.wr_drop)
        begin
            ws_next = cur_last ? txrc_pkg::WS_IDLE : txrc_pkg::WS_DROP;
        end
        if (cmd.wr_store)
        begin
            len_next[fill_reg] = LEN_W'(len_rd + 1'b1);
            if (store_fills)
            begin
                fill_next = fill_nx;
                if (hits)
                begin
                    ovr_next = 1'b1;
                end
            end
            if (cur_last)
                ws_next = txrc_pkg::WS_IDLE;
            else if (store_fills && hits)
                ws_next = txrc_pkg::WS_DROP;
            else
                ws_next = txrc_pkg::WS_ACCEPT;
        end
        if (cmd.wr_advance)
        begin
            fill_next = fill_nx;
            if (hits)
            begin
                ovr_next = 1'b1;
                ws_next  = cur_last ? txrc_pkg::WS_IDLE : txrc_pkg::WS_DROP;
            end
        end
        if (cmd.wr_exhaust)
        begin
            ws_next = cur_last ? txrc_pkg::WS_IDLE : txrc_pkg::WS_ACCEPT;
        end
        if (cmd.retire)
        begin
            busy_next          = 1'b0;
            len_next[send_reg] = '0;
            send_next          = next_idx(send_reg);
            ovr_next           = 1'b0;
            done_next          = 1'b0;
        end
        if (cmd.start)
        begin
            busy_next    = 1'b1;
            run_len_next = len_rd;
            rd_cnt_next  = '0;
            if (fill_reg == send_reg)
            begin
                fill_next = fill_nx;
            end
        end

        // read stage: RAM output is held until it moves to the output register
        if (issue)
        begin
            rd_cnt_next            = LEN_W'(rd_cnt_reg + 1'b1);
            pend_next.tx_byte      = '0;
            pend_next.buffer_index = 2'(send_reg);
            pend_next.tx_length    = 7'(run_len_reg);
            pend_next.last_byte    = issue_last;
            pend_next.overrun_flag = ovr_reg;
        end
        pend_valid_next = issue || (pend_valid_reg && !pend_move);

        if (pend_move)
        begin
            out_next         = pend_reg;
            out_next.tx_byte = ram_rd;
            out_valid_next   = 1'b1;
        end
        else if (tx_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUFFER_COUNT; i++)
            begin
                len_reg[i] <= '0;
            end
            fill_reg       <= '0;
            send_reg       <= '0;
            busy_reg       <= 1'b0;
            ovr_reg        <= 1'b0;
            done_reg       <= 1'b0;
            ws_reg         <= txrc_pkg::WS_IDLE;
            run_len_reg    <= '0;
            rd_cnt_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            len_reg        <= len_next;
            fill_reg       <= fill_next;
            send_reg       <= send_next;
            busy_reg       <= busy_next;
            ovr_reg        <= ovr_next;
            done_reg       <= done_next;
            ws_reg         <= ws_next;
            run_len_reg    <= run_len_next;
            rd_cnt_reg     <= rd_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign tx_valid = out_valid_reg;
    assign tx_item  = out_reg;

    `ASSERT_IMPLIES(a_len_bound, clk, rst_n, 1'b1, len_rd <= LEN_FULL,
        "buffer length beyond buffer size")
    `ASSERT_IMPLIES(a_no_issue_on_stall, clk, rst_n, issue,
        !(pend_valid_reg && out_valid_reg && !tx_ready), "read issued into full stages")
    `ASSERT_NEXT(a_start_busy, clk, rst_n, cmd.start, busy_reg,
        "transmitter not busy after start")

endmodule

// File: rtl/txrc_ctrl.sv
// ----------------------------------------------------------------------------
// txrc_ctrl
// Controller: takes items, sequences full-buffer skipping, the tick check
// and the read-out of a buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module txrc_ctrl #(
    parameter int BUFFER_COUNT = txrc_pkg::BUFFER_COUNT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [1:0]           item_cmd,
    output logic                 item_ready,
    input  txrc_pkg::dp_status_t sts,
    output txrc_pkg::ctrl_cmd_t  cmd
);

    localparam int K_W = $clog2(BUFFER_COUNT + 1);
    localparam logic [K_W-1:0] K_MAX = K_W'(BUFFER_COUNT);

    txrc_pkg::ctrl_state_t state_reg, state_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic                  skip_step;

    assign skip_step = sts.fill_full && (k_reg < K_MAX);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            txrc_pkg::ST_IDLE:
            begin
                k_next = '0;
                if (item_valid)
                begin
                    if (item_cmd == txrc_pkg::CMD_WRITE && sts.wr_accept && sts.fill_full)
                        state_next = txrc_pkg::ST_SKIP;
                    else if (item_cmd == txrc_pkg::CMD_TICK)
                        state_next = txrc_pkg::ST_CHECK;
                end
            end
            txrc_pkg::ST_SKIP:
            begin
                if (skip_step)
                begin
                    k_next = K_W'(k_reg + 1'b1);
                    if (sts.adv_hits_send)
                        state_next = txrc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = txrc_pkg::ST_IDLE;
                end
            end
            txrc_pkg::ST_CHECK:
            begin
                state_next = sts.can_start ? txrc_pkg::ST_SEND : txrc_pkg::ST_IDLE;
            end
            txrc_pkg::ST_SEND:
            begin
                if (sts.issue_last)
                    state_next = txrc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = txrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            txrc_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    case (item_cmd)
                        txrc_pkg::CMD_WRITE:
                        begin
                            cmd.lat_item = 1'b1;
                            if (!sts.wr_accept)
                                cmd.wr_drop = 1'b1;
                            else if (!sts.fill_full)
                                cmd.wr_store = 1'b1;
                        end
                        txrc_pkg::CMD_TICK:
                        begin
                            cmd.retire = sts.done;
                        end
                        txrc_pkg::CMD_DONE:
                        begin
                            cmd.set_done = 1'b1;
                        end
                        default:
                        begin
                            cmd.set_done = 1'b0;
                        end
                    endcase
                end
            end
            txrc_pkg::ST_SKIP:
            begin
                cmd.src_latched = 1'b1;
                if (skip_step)
                    cmd.wr_advance = 1'b1;
                else if (!sts.fill_full)
                    cmd.wr_store = 1'b1;
                else
                    cmd.wr_exhaust = 1'b1;
            end
            txrc_pkg::ST_CHECK:
            begin
                cmd.len_at_send = 1'b1;
                cmd.start       = sts.can_start;
            end
            txrc_pkg::ST_SEND:
            begin
                cmd.send_en = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= txrc_pkg::ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    `ASSERT_NEXT(a_send_exit, clk, rst_n,
        state_reg == txrc_pkg::ST_SEND && sts.issue_last,
        state_reg == txrc_pkg::ST_IDLE, "send run did not end after last read")
    `ASSERT_IMPLIES(a_skip_bound, clk, rst_n, state_reg == txrc_pkg::ST_SKIP,
        k_reg <= K_MAX, "skip loop ran past ring size")

endmodule

// File: rtl/tx_buffer_ring_coalescer_unit.sv
// ----------------------------------------------------------------------------
// tx_buffer_ring_coalescer_unit
// Ring of transmit buffers that coalesces byte writes and streams buffers out.
// ----------------------------------------------------------------------------
// Channels: host carries one item per command: a byte write (with an end of
// write mark), a service tick or a transfer completion event. tx carries one
// item per byte sent, with buffer index, length, last mark and overrun state.
// A write that meets a full fill buffer steps over one buffer per cycle, up to
// BUFFER_COUNT buffers. A tick that starts a buffer blocks the host channel
// while its bytes are read, one per cycle while tx does not stall, through
// the single read port of the byte store.
// The tx side has a read stage and an output register: when tx stalls, reads
// stop and no byte is lost; host items are taken again once all reads of the
// run are issued, while the last bytes drain.
// Reset clears lengths, indices and flags at once; no clearing pass. Bytes
// of the store are never read before they are written.
// ----------------------------------------------------------------------------
module tx_buffer_ring_coalescer_unit #(
    parameter int BUFFER_BYTES = txrc_pkg::BUFFER_BYTES_DEFAULT,
    parameter int BUFFER_COUNT = txrc_pkg::BUFFER_COUNT_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    txrc_stream_if.sink      host,
    txrc_stream_if.source    tx
);

    txrc_pkg::ctrl_cmd_t  cmd;
    txrc_pkg::dp_status_t sts;
    txrc_pkg::in_item_t   host_item;
    txrc_pkg::out_item_t  tx_item;
    logic                 host_ready;
    logic                 tx_valid;

    assign host_item  = host.payload;
    assign host.ready = host_ready;
    assign tx.valid   = tx_valid;
    assign tx.payload = tx_item;

    txrc_ctrl #(
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (host.valid),
        .item_cmd   (host_item.cmd),
        .item_ready (host_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    txrc_dp #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .data_byte     (host_item.data_byte),
        .last_of_write (host_item.last_of_write),
        .tx_ready      (tx.ready),
        .tx_valid      (tx_valid),
        .tx_item       (tx_item)
    );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the transmit buffer ring coalescer. Host items (byte writes,
// service ticks, completion events, unused codes) go in over a valid/ready
// channel. A predictor of the ring works out every byte that each tick sends,
// and each tx item is compared field by field with the oldest prediction.
// Tests cover directed command sequences, random host traffic, a long tx
// stall against a busy host, and overruns both mid-write and on the last byte.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING       = txrc_pkg::BUFFER_COUNT_DEFAULT;
    localparam int BUF_BYTES  = txrc_pkg::BUFFER_BYTES_DEFAULT;
    localparam int BYTE_IDX_W = $clog2(BUF_BYTES);
    localparam int LIMIT      = 600000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    txrc_stream_if #(.payload_t(txrc_pkg::in_item_t))  host_if ();
    txrc_stream_if #(.payload_t(txrc_pkg::out_item_t)) tx_if ();

    tx_buffer_ring_coalescer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .host  (host_if),
        .tx    (tx_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ring predictor state
    logic [7:0] ring_bytes [RING][BUF_BYTES];
    logic [6:0] ring_len [RING];
    logic [1:0] fill_idx;
    logic [1:0] send_idx;
    bit         tx_busy;
    bit         overrun;
    bit         done_pending;
    txrc_pkg::wr_state_t wr_state;

    txrc_pkg::out_item_t pending_tx_bytes [$];

    int cycle_count;
    int fail_count;
    int host_items;
    int tx_checked;
    int overrun_events;
    int runs_started;
    int rx_hold_req;
    bit host_gaps_on = 1'b1;

    function automatic logic [1:0] ring_next(input logic [1:0] idx);
        return (idx == 2'(RING - 1)) ? 2'd0 : idx + 2'd1;
    endfunction

    function automatic bit ring_step_fill();
        fill_idx = ring_next(fill_idx);
        if (fill_idx == send_idx)
        begin
            overrun  = 1'b1;
            wr_state = txrc_pkg::WS_DROP;
            overrun_events++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void ring_write(input logic [7:0] data, input logic last);
        bit dropped;
        int k;
        dropped = 1'b0;
        if (wr_state == txrc_pkg::WS_IDLE)
            wr_state = (!overrun && (!tx_busy || fill_idx != send_idx))
                     ? txrc_pkg::WS_ACCEPT : txrc_pkg::WS_DROP;
        if (wr_state == txrc_pkg::WS_ACCEPT)
        begin
            for (k = 0; k < RING && !dropped && ring_len[fill_idx] >= BUF_BYTES; k++)
                dropped = ring_step_fill();
            if (!dropped && ring_len[fill_idx] < BUF_BYTES)
            begin
                ring_bytes[fill_idx][BYTE_IDX_W'(ring_len[fill_idx])] = data;
                ring_len[fill_idx] = ring_len[fill_idx] + 7'd1;
                if (ring_len[fill_idx] == BUF_BYTES)
                    void'(ring_step_fill());
            end
        end
        if (last)
            wr_state = txrc_pkg::WS_IDLE;
    endfunction

    function automatic void ring_tick();
        int n;
        int i;
        txrc_pkg::out_item_t r;
        if (done_pending)
        begin
            tx_busy            = 1'b0;
            ring_len[send_idx] = '0;
            send_idx           = ring_next(send_idx);
            overrun            = 1'b0;
            done_pending       = 1'b0;
        end
        n = int'(ring_len[send_idx]);
        if (tx_busy || n == 0)
            return;
        if (n > BUF_BYTES)
            n = BUF_BYTES;
        tx_busy = 1'b1;
        if (fill_idx == send_idx)
            fill_idx = ring_next(fill_idx);
        runs_started++;
        for (i = 0; i < n; i++)
        begin
            r.tx_byte      = ring_bytes[send_idx][BYTE_IDX_W'(i)];
            r.buffer_index = send_idx;
            r.tx_length    = 7'(n);
            r.last_byte    = (i == n - 1);
            r.overrun_flag = overrun;
            pending_tx_bytes.push_back(r);
        end
    endfunction

    function automatic void ring_apply_item(input txrc_pkg::in_item_t it);
        case (it.cmd)
            txrc_pkg::CMD_WRITE: ring_write(it.data_byte, it.last_of_write);
            txrc_pkg::CMD_TICK:  ring_tick();
            txrc_pkg::CMD_DONE:  done_pending = 1'b1;
            default:   ;
        endcase
    endfunction

    function automatic int ring_bytes_held();
        int total;
        total = 0;
        foreach (ring_len[b])
            total += int'(ring_len[b]);
        return total;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // One host item; the predictor advances at the accepting edge.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input logic last);
        txrc_pkg::in_item_t it;
        int gap;
        it.cmd           = cmd;
        it.data_byte     = data;
        it.last_of_write = last;
        gap = host_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            host_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        host_if.valid   <= 1'b1;
        host_if.payload <= it;
        do
            @(posedge clk);
        while (!host_if.ready);
        ring_apply_item(it);
        host_items++;
    endtask

    task automatic send_write(input int len, input bit interleave);
        int i;
        for (i = 0; i < len; i++)
        begin
            if (interleave && $urandom_range(0, 15) == 0)
                send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
            send_item(txrc_pkg::CMD_WRITE, 8'($urandom), i == len - 1);
        end
    endtask

    task automatic pause_until_drained();
        host_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_tx_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Close any open write, retire everything, line fill up with send.
    task automatic settle_ring();
        int guard;
        guard = 0;
        if (wr_state != txrc_pkg::WS_IDLE)
            send_item(txrc_pkg::CMD_WRITE, 8'($urandom), 1'b1);
        while ((tx_busy || overrun || fill_idx != send_idx || ring_bytes_held() != 0)
               && guard < 16)
        begin
            send_item(txrc_pkg::CMD_DONE, 8'($urandom), 1'($urandom));
            send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
            guard++;
        end
        pause_until_drained();
    endtask

    task automatic test_directed_commands();
        send_item(CMD_UNUSED, 8'hFF, 1'b1);
        send_item(txrc_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(txrc_pkg::CMD_WRITE, 8'h00, 1'b0);
        send_item(txrc_pkg::CMD_WRITE, 8'hFF, 1'b0);
        send_item(txrc_pkg::CMD_WRITE, 8'h5A, 1'b0);
        send_item(txrc_pkg::CMD_WRITE, 8'hA5, 1'b1);
        send_item(txrc_pkg::CMD_TICK, 8'hFF, 1'b1);
        send_item(txrc_pkg::CMD_WRITE, 8'h80, 1'b1);
        send_item(txrc_pkg::CMD_TICK, 8'h01, 1'b0);
        send_item(txrc_pkg::CMD_DONE, 8'hFE, 1'b1);
        send_item(txrc_pkg::CMD_TICK, 8'h00, 1'b0);
        send_item(txrc_pkg::CMD_DONE, 8'h00, 1'b0);
        send_item(txrc_pkg::CMD_TICK, 8'h00, 1'b0);
        // completion with nothing in flight
        send_item(txrc_pkg::CMD_DONE, 8'h7F, 1'b0);
        send_item(txrc_pkg::CMD_TICK, 8'h00, 1'b1);
        send_item(CMD_UNUSED, 8'h00, 1'b0);
        pause_until_drained();
    endtask

    task automatic test_random_traffic();
        int n;
        int sel;
        int len;
        n = 0;
        while (n < 35)
        begin
            if ($urandom_range(0, 29) == 0)
                host_gaps_on = !host_gaps_on;
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
                send_write(len, 1'b1);
                n += len;
            end
            else if (sel < 72)
            begin
                send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
                n++;
            end
            else if (sel < 86)
            begin
                send_item(txrc_pkg::CMD_DONE, 8'($urandom), 1'($urandom));
                n++;
            end
            else if (sel < 94)
            begin
                send_item(txrc_pkg::CMD_DONE, 8'($urandom), 1'($urandom));
                send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
                n += 2;
            end
            else
            begin
                send_item(CMD_UNUSED, 8'($urandom), 1'($urandom));
                n++;
            end
        end
        host_gaps_on = 1'b1;
        pause_until_drained();
    endtask

    task automatic test_tx_backpressure();
        settle_ring();
        send_write(40, 1'b0);
        rx_hold_req  = 300;
        host_gaps_on = 1'b0;
        send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
        send_write(16, 1'b0);
        host_gaps_on = 1'b1;
        pause_until_drained();
    endtask

    task automatic test_ring_overrun();
        settle_ring();
        send_write(8, 1'b0);
        send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
        // three buffers to fill, then the rest of the write is lost
        send_write(3 * BUF_BYTES + $urandom_range(1, 24), 1'b0);
        send_write(3, 1'b0);
        send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
        send_item(txrc_pkg::CMD_DONE, 8'($urandom), 1'($urandom));
        send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
        // exactly one buffer of room: overrun lands on the last byte
        send_write(BUF_BYTES, 1'b0);
        send_write(2, 1'b0);
        send_item(txrc_pkg::CMD_DONE, 8'($urandom), 1'($urandom));
        send_item(txrc_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
        pause_until_drained();
    endtask

    always @(posedge clk)
    begin
        txrc_pkg::out_item_t got;
        txrc_pkg::out_item_t want;
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            got = tx_if.payload;
            if (pending_tx_bytes.size() == 0)
                report_mismatch("unexpected tx item, byte", int'(got.tx_byte), -1);
            else
            begin
                want = pending_tx_bytes.pop_front();
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", int'(got.tx_byte), int'(want.tx_byte));
                if (got.buffer_index !== want.buffer_index)
                    report_mismatch("buffer_index", int'(got.buffer_index),
                                    int'(want.buffer_index));
                if (got.tx_length !== want.tx_length)
                    report_mismatch("tx_length", int'(got.tx_length), int'(want.tx_length));
                if (got.last_byte !== want.last_byte)
                    report_mismatch("last_byte", int'(got.last_byte), int'(want.last_byte));
                if (got.overrun_flag !== want.overrun_flag)
                    report_mismatch("overrun_flag", int'(got.overrun_flag),
                                    int'(want.overrun_flag));
            end
            tx_checked++;
        end
    end

    // tx receiver: random stalls in alternating stretches, plus requested holds
    initial
    begin
        int stall_left;
        int phase_cnt;
        bit stalls_on;
        stall_left = 0;
        phase_cnt  = 0;
        stalls_on  = 1'b1;
        tx_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                phase_cnt++;
                if (phase_cnt == 400)
                begin
                    phase_cnt = 0;
                    stalls_on = !stalls_on;
                end
                if (rx_hold_req > 0)
                begin
                    stall_left  = rx_hold_req;
                    rx_hold_req = 0;
                end
                if (stall_left > 0)
                begin
                    tx_if.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    tx_if.ready <= 1'b1;
                    if (stalls_on)
                        stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
        cycle_count++;

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        host_if.valid   = 1'b0;
        host_if.payload = '0;
        foreach (ring_len[b])
            ring_len[b] = '0;
        foreach (ring_bytes[b, i])
            ring_bytes[b][i] = '0;
        fill_idx     = '0;
        send_idx     = '0;
        tx_busy      = 1'b0;
        overrun      = 1'b0;
        done_pending = 1'b0;
        wr_state     = txrc_pkg::WS_IDLE;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_commands();
        test_random_traffic();
        test_tx_backpressure();
        test_ring_overrun();

        host_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_tx_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (pending_tx_bytes.size() != 0)
            report_mismatch("tx items never seen", pending_tx_bytes.size(), 0);

        $display("host items %0d, tx items checked %0d, buffer runs %0d",
                 host_items, tx_checked, runs_started);
        $display("overruns %0d, mismatches %0d", overrun_events, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
